// File: src/vln_pkg.sv
// Shared constants, width helpers and control structs for the L2 vector normalizer.
package vln_pkg;

    localparam int MAX_LEN_DEF    = 64;
    localparam int ELEM_WIDTH_DEF = 16;
    localparam int SUM_CAP        = 64;

    // Width of the saturating sum of squares for a given element width
    function automatic int sum_width(int ew);
        int w;
        w = 2 * ew + 5;
        return (w > SUM_CAP) ? SUM_CAP : w;
    endfunction

    // Width of the integer square root of that sum
    function automatic int root_width(int ew);
        int s;
        s = sum_width(ew);
        return (s + 1) / 2;
    endfunction

    // Commands from the controller to the datapath
    typedef struct packed {
        logic store;
        logic square;
        logic accum;
        logic root_start;
        logic read;
        logic div_start;
        logic load;
        logic next;
        logic clear;
    } vln_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic full;
        logic root_done;
        logic div_done;
        logic last_idx;
        logic out_free;
    } vln_stat_t;

endpackage

// File: src/vln_sqrt.sv
// Iterative floor square root, one root bit per cycle.
module vln_sqrt #(
    parameter int SUM_W  = 37,
    parameter int ROOT_W = 19
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [SUM_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W+1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [ROOT_W+1:0] rem_sh;
    logic [ROOT_W+1:0] trial;
    logic              ge;

    // Bring down two radicand bits and try the next root bit
    always_comb begin
        rem_sh = {rem_reg[ROOT_W-1:0], rad_reg[RAD_W-1 -: 2]};
        trial  = {root_reg, 2'b01};
        ge     = (rem_sh >= trial);
    end

    // Sequence the iterations
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Advance the partial remainder and root
    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= RAD_W'(radicand);
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: src/vln_div.sv
// Restoring divider for (magnitude << FRAC) / norm, one quotient bit per cycle.
module vln_div #(
    parameter int ELEM_W = 16,
    parameter int ROOT_W = 19
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [ELEM_W-1:0] dividend,
    input  logic [ROOT_W-1:0] divisor,
    output logic              done,
    output logic [ELEM_W-2:0] quotient
);

    localparam int QW    = ELEM_W - 1;
    localparam int CNT_W = $clog2(QW + 1);

    logic [ROOT_W-1:0] rem_reg;
    logic [QW-1:0]     bits_reg;
    logic [QW-1:0]     q_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [ROOT_W:0]   rem_sh;
    logic [ROOT_W:0]   diff;
    logic              ge;

    // Shift in the next dividend bit and compare against the norm
    always_comb begin
        rem_sh = {rem_reg, bits_reg[QW-1]};
        diff   = rem_sh - {1'b0, divisor};
        ge     = (rem_sh >= {1'b0, divisor});
    end

    // Sequence the iterations
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The magnitude never exceeds the norm, so the upper dividend bits
    // preload the remainder and only the low quotient bits are produced
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= ROOT_W'(dividend >> 1);
            bits_reg <= QW'(dividend[0]) << (QW - 1);
            q_reg    <= '0;
        end else if (busy_reg) begin
            rem_reg  <= ge ? diff[ROOT_W-1:0] : rem_sh[ROOT_W-1:0];
            bits_reg <= bits_reg << 1;
            q_reg    <= {q_reg[QW-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// File: src/vln_dp.sv
// Datapath: element store, sum of squares, root and divider units, result register.
module vln_dp #(
    parameter int MAX_LEN = vln_pkg::MAX_LEN_DEF,
    parameter int ELEM_W  = vln_pkg::ELEM_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  vln_pkg::vln_cmd_t        cmd,
    output vln_pkg::vln_stat_t       stat,
    input  logic signed [ELEM_W-1:0] s_element,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [ELEM_W-1:0] m_unit_element,
    output logic                     m_final_res,
    output logic                     m_zero_norm,
    output logic                     m_truncated
);

    localparam int FRAC   = ELEM_W - 2;
    localparam int SUM_W  = vln_pkg::sum_width(ELEM_W);
    localparam int ROOT_W = vln_pkg::root_width(ELEM_W);
    localparam int SQ_W   = 2 * ELEM_W - 1;
    localparam int AW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW     = $clog2(MAX_LEN + 1);

    logic [ELEM_W-1:0] mem [MAX_LEN];

    logic [CW-1:0]     count_reg;
    logic              overflow_reg;
    logic [AW-1:0]     rd_idx_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [ELEM_W-1:0] mag_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [ELEM_W-1:0] rd_data_reg;
    logic              neg_reg;
    logic              m_valid_reg;
    logic [ELEM_W-1:0] m_unit_reg;
    logic              m_final_reg;
    logic              m_zero_reg;
    logic              m_trunc_reg;

    logic [ELEM_W-1:0] s_raw;
    logic [ELEM_W-1:0] s_mag;
    logic [ELEM_W-1:0] rd_mag;
    logic [SUM_W:0]    sum_ext;
    logic [SUM_W-1:0]  sum_next;
    logic [ROOT_W-1:0] norm;
    logic              root_done;
    logic              div_done;
    logic [ELEM_W-2:0] quotient;
    logic [ELEM_W-1:0] q_w;
    logic [ELEM_W-1:0] q_lim;
    logic [ELEM_W-1:0] q_sat;
    logic [ELEM_W-1:0] unit_next;
    logic              zero_norm;

    // Magnitudes of the incoming and the stored element
    always_comb begin
        s_raw  = s_element;
        s_mag  = s_raw[ELEM_W-1] ? (~s_raw + 1'b1) : s_raw;
        rd_mag = rd_data_reg[ELEM_W-1] ? (~rd_data_reg + 1'b1) : rd_data_reg;
    end

    // Saturating accumulate of the squared magnitude
    always_comb begin
        sum_ext  = {1'b0, sum_reg} + (SUM_W + 1)'(sq_reg);
        sum_next = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
    end

    // Clamp, apply sign, force zero for a zero norm
    always_comb begin
        zero_norm = (norm == '0);
        q_w       = ELEM_W'(quotient);
        q_lim     = ELEM_W'(1) << FRAC;
        q_sat     = (q_w > q_lim) ? q_lim : q_w;
        if (zero_norm) begin
            unit_next = '0;
        end else begin
            unit_next = neg_reg ? (~q_sat + 1'b1) : q_sat;
        end
    end

    // Element store: write on request, registered read
    always_ff @(posedge aclk) begin
        if (cmd.store && !stat.full) begin
            mem[count_reg[AW-1:0]] <= s_raw;
        end
        if (cmd.read) begin
            rd_data_reg <= mem[rd_idx_reg];
        end
    end

    // Vector bookkeeping and output handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            rd_idx_reg   <= '0;
            sum_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.store) begin
                if (stat.full) begin
                    overflow_reg <= 1'b1;
                end else begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.accum) begin
                sum_reg <= sum_next;
            end
            if (cmd.next) begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
            if (cmd.clear) begin
                count_reg    <= '0;
                overflow_reg <= 1'b0;
                rd_idx_reg   <= '0;
                sum_reg      <= '0;
            end
            if (cmd.load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.store && !stat.full) begin
            mag_reg <= s_mag;
        end
        if (cmd.square) begin
            sq_reg <= SQ_W'(mag_reg) * SQ_W'(mag_reg);
        end
        if (cmd.div_start) begin
            neg_reg <= rd_data_reg[ELEM_W-1];
        end
        if (cmd.load) begin
            m_unit_reg  <= unit_next;
            m_final_reg <= stat.last_idx;
            m_zero_reg  <= zero_norm;
            m_trunc_reg <= overflow_reg;
        end
    end

    vln_sqrt #(
        .SUM_W  (SUM_W),
        .ROOT_W (ROOT_W)
    ) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.root_start),
        .radicand (sum_reg),
        .done     (root_done),
        .root     (norm)
    );

    vln_div #(
        .ELEM_W (ELEM_W),
        .ROOT_W (ROOT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (rd_mag),
        .divisor  (norm),
        .done     (div_done),
        .quotient (quotient)
    );

    // Status back to the controller
    always_comb begin
        stat.full      = (count_reg == CW'(MAX_LEN));
        stat.root_done = root_done;
        stat.div_done  = div_done;
        stat.last_idx  = ((CW'(rd_idx_reg) + CW'(1)) == count_reg);
        stat.out_free  = !m_valid_reg || m_ready;
    end

    assign m_valid        = m_valid_reg;
    assign m_unit_element = m_unit_reg;
    assign m_final_res    = m_final_reg;
    assign m_zero_norm    = m_zero_reg;
    assign m_truncated    = m_trunc_reg;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_LEN))
        else $error("element count beyond capacity");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten while held");

    a_zero_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_zero_reg) |-> (m_unit_reg == '0))
        else $error("zero norm result is not zero");
`endif

endmodule

// File: src/vln_ctrl.sv
// Controller state machine: collect phase, root, and per-element divide and emit.
module vln_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_last,
    input  vln_pkg::vln_stat_t stat,
    output vln_pkg::vln_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQ    = 4'd1;
    localparam logic [3:0] S_ACC   = 4'd2;
    localparam logic [3:0] S_ROOT  = 4'd3;
    localparam logic [3:0] S_RWAIT = 4'd4;
    localparam logic [3:0] S_READ  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_DWAIT = 4'd7;
    localparam logic [3:0] S_LOAD  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       last_reg;
    logic       last_next;

    // Next state and command decode
    always_comb begin
        state_next = state_reg;
        last_next  = last_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.store = 1'b1;
                    last_next = s_last;
                    if (!stat.full) begin
                        state_next = S_SQ;
                    end else if (s_last) begin
                        state_next = S_ROOT;
                    end
                end
            end
            S_SQ: begin
                cmd.square = 1'b1;
                state_next = S_ACC;
            end
            S_ACC: begin
                cmd.accum  = 1'b1;
                state_next = last_reg ? S_ROOT : S_IDLE;
            end
            S_ROOT: begin
                cmd.root_start = 1'b1;
                state_next     = S_RWAIT;
            end
            S_RWAIT: begin
                if (stat.root_done) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                cmd.read   = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.div_start = 1'b1;
                state_next    = S_DWAIT;
            end
            S_DWAIT: begin
                if (stat.div_done) begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                if (stat.out_free) begin
                    cmd.load = 1'b1;
                    if (stat.last_idx) begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        cmd.next   = 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_one_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.store, cmd.square, cmd.accum, cmd.root_start, cmd.read,
                  cmd.div_start, cmd.load}))
        else $error("more than one datapath step issued");

    a_load_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LOAD && !stat.out_free) |=> (state_reg == S_LOAD))
        else $error("left load state with result slot busy");

    a_root_when: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.root_done |-> (state_reg == S_RWAIT))
        else $error("root finished outside its wait state");
`endif

endmodule

// File: src/vector_l2_normalizer.sv
// Input: a stored element passes through accept, square and accumulate; a dropped one is
// only accepted. After the last element the bit-serial root unit computes the square root.
// Each result then goes through a store read, ELEM_WIDTH-1 divider steps and a load into the
// output register; the load waits while that register holds a result not yet accepted.
// Reset (aresetn low, synchronous) empties the vector and the output register.
module vector_l2_normalizer #(
    parameter int MAX_LEN    = vln_pkg::MAX_LEN_DEF,
    parameter int ELEM_WIDTH = vln_pkg::ELEM_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [ELEM_WIDTH-1:0] s_element,
    input  logic                         s_last,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [ELEM_WIDTH-1:0] m_unit_element,
    output logic                         m_final_res,
    output logic                         m_zero_norm,
    output logic                         m_truncated
);

    vln_pkg::vln_cmd_t  cmd;
    vln_pkg::vln_stat_t stat;

    vln_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_last  (s_last),
        .stat    (stat),
        .cmd     (cmd)
    );

    vln_dp #(
        .MAX_LEN (MAX_LEN),
        .ELEM_W  (ELEM_WIDTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_element      (s_element),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_unit_element (m_unit_element),
        .m_final_res    (m_final_res),
        .m_zero_norm    (m_zero_norm),
        .m_truncated    (m_truncated)
    );

endmodule
